[src/reshuf_pkg.sv]
package reshuf_pkg;

  localparam int MAX_NODES   = 16;
  localparam int TABLE_DEPTH = 256;

  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int ID_W    = $clog2(MAX_NODES);
  localparam int PAIR_W  = 2 * ID_W;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

  localparam int NODE_COUNT_W = 5;
  localparam int EDGE_LIMIT_W = 9;
  localparam int OPTIONS_W    = 2;
  localparam int WORD_W       = 31;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [1:0] REG_EDGE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_EDGE_OPTIONS = 2'd2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  localparam int OPT_UNDIRECTED = 0;
  localparam int OPT_LOOPS      = 1;

  // Remainder unit: MOD_STEP dividend bits retired per cycle.
  localparam int MOD_STEP   = 4;
  localparam int MOD_CYCLES = (WORD_W + MOD_STEP - 1) / MOD_STEP;
  localparam int MOD_DIVD_W = MOD_CYCLES * MOD_STEP;
  localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  typedef struct packed {
    logic [NODE_COUNT_W-1:0] node_count;
    logic [EDGE_LIMIT_W-1:0] edge_limit;
    logic [OPTIONS_W-1:0]    edge_options;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0] edge_from;
    logic [ID_W-1:0] edge_to;
    logic            last_edge;
    logic            exhausted;
  } result_t;

endpackage

[src/reshuf_ram.sv]
module reshuf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/reshuf_mod_unit.sv]
module reshuf_mod_unit (
  input  logic                clk,
  input  logic                rst,
  input  reshuf_pkg::mod_req_t req,
  output reshuf_pkg::mod_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [reshuf_pkg::MOD_CNT_W-1:0]  cnt;
  logic [reshuf_pkg::MOD_DIVD_W-1:0] quo;
  logic [reshuf_pkg::CNT_W-1:0]      rem;
  logic [reshuf_pkg::CNT_W-1:0]      dv;
  logic [reshuf_pkg::MOD_DIVD_W-1:0] quo_next;
  logic [reshuf_pkg::CNT_W-1:0]      rem_next;

  // Restoring remainder, MOD_STEP bits per cycle; the partial remainder stays below dv.
  always_comb begin
    logic [reshuf_pkg::CNT_W:0] t;
    t        = '0;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < reshuf_pkg::MOD_STEP; i++) begin
      t = {rem_next, quo_next[reshuf_pkg::MOD_DIVD_W-1]};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
      end
      rem_next = t[reshuf_pkg::CNT_W-1:0];
      quo_next = quo_next << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start
              && (cnt == reshuf_pkg::MOD_CNT_W'(reshuf_pkg::MOD_CYCLES - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == reshuf_pkg::MOD_CNT_W'(reshuf_pkg::MOD_CYCLES - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= reshuf_pkg::MOD_DIVD_W'(req.word);
      rem <= '0;
      dv  <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

[src/reshuf_ctrl.sv]
module reshuf_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                kind,
  input  logic [reshuf_pkg::WORD_W-1:0]       word,
  input  reshuf_pkg::cfg_t                    cfg,
  output logic                                idle,
  output reshuf_pkg::mod_req_t                mod_req,
  input  reshuf_pkg::mod_rsp_t                mod_rsp,
  output logic                                ram_we,
  output logic [reshuf_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [reshuf_pkg::PAIR_W-1:0]       ram_wdata,
  output logic [reshuf_pkg::ADDR_W-1:0]       ram_raddr,
  input  logic [reshuf_pkg::PAIR_W-1:0]       ram_rdata,
  output logic                                res_valid,
  input  logic                                res_take,
  output reshuf_pkg::result_t                 res
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_BUILD  = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_RD_POS = 8'b0000_1000,
    ST_RD_CNT = 8'b0001_0000,
    ST_WR_POS = 8'b0010_0000,
    ST_WR_CNT = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t                            state;
  logic [reshuf_pkg::NODE_W-1:0]     bu;
  logic [reshuf_pkg::NODE_W-1:0]     bv;
  logic                              brev;
  logic [reshuf_pkg::CNT_W-1:0]      total;
  logic [reshuf_pkg::CNT_W-1:0]      drawn;
  logic [reshuf_pkg::CNT_W-1:0]      limit;
  logic [reshuf_pkg::ADDR_W-1:0]     pos;
  logic [reshuf_pkg::PAIR_W-1:0]     picked;

  logic [reshuf_pkg::NODE_W-1:0]     n;
  logic                              undirected;
  logic                              loops;
  logic                              b_write;
  logic                              b_store;
  logic [reshuf_pkg::PAIR_W-1:0]     b_pair;
  logic                              no_draw;
  logic [reshuf_pkg::CNT_W-1:0]      pos_full;
  logic [reshuf_pkg::CNT_W-1:0]      drawn_inc;

  always_comb begin
    if (32'(cfg.node_count) > reshuf_pkg::MAX_NODES) begin
      n = reshuf_pkg::NODE_W'(reshuf_pkg::MAX_NODES);
    end else begin
      n = reshuf_pkg::NODE_W'(cfg.node_count);
    end
  end

  assign undirected = cfg.edge_options[reshuf_pkg::OPT_UNDIRECTED];
  assign loops      = cfg.edge_options[reshuf_pkg::OPT_LOOPS];

  // Builder walk: for node bu, the pairs with bv above it (and the mirrored pair when
  // directed), then the self loop, if enabled, once bv runs past the last node.
  always_comb begin
    b_write = 1'b0;
    b_pair  = '0;
    if (bu < n) begin
      if (bv < n) begin
        b_write = 1'b1;
        if (brev) begin
          b_pair = {bv[reshuf_pkg::ID_W-1:0], bu[reshuf_pkg::ID_W-1:0]};
        end else begin
          b_pair = {bu[reshuf_pkg::ID_W-1:0], bv[reshuf_pkg::ID_W-1:0]};
        end
      end else if (loops) begin
        b_write = 1'b1;
        b_pair  = {bu[reshuf_pkg::ID_W-1:0], bu[reshuf_pkg::ID_W-1:0]};
      end
    end
  end

  assign b_store   = b_write && (total < reshuf_pkg::CNT_W'(reshuf_pkg::TABLE_DEPTH));
  assign no_draw   = (drawn >= limit) || (drawn >= total);
  assign pos_full  = drawn + mod_rsp.rem;
  assign drawn_inc = drawn + 1'b1;

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_EMIT);

  assign mod_req.start   = idle && accept && (kind == reshuf_pkg::KIND_DRAW) && !no_draw;
  assign mod_req.word    = word;
  assign mod_req.divisor = total - drawn;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = total[reshuf_pkg::ADDR_W-1:0];
    ram_wdata = b_pair;
    ram_raddr = pos;
    case (state)
      ST_BUILD: begin
        ram_we = (bu < n) && b_store;
      end
      ST_RD_CNT: begin
        ram_raddr = drawn[reshuf_pkg::ADDR_W-1:0];
      end
      ST_WR_POS: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = ram_rdata;
      end
      ST_WR_CNT: begin
        ram_we    = 1'b1;
        ram_waddr = drawn[reshuf_pkg::ADDR_W-1:0];
        ram_wdata = picked;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
      drawn <= '0;
      limit <= '0;
      bu    <= '0;
      bv    <= '0;
      brev  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == reshuf_pkg::KIND_START) begin
              bu    <= '0;
              bv    <= reshuf_pkg::NODE_W'(1);
              brev  <= 1'b0;
              total <= '0;
              state <= ST_BUILD;
            end else if (no_draw) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_BUILD: begin
          if (bu >= n) begin
            if (32'(cfg.edge_limit) < 32'(total)) begin
              limit <= reshuf_pkg::CNT_W'(cfg.edge_limit);
            end else begin
              limit <= total;
            end
            drawn <= '0;
            state <= ST_IDLE;
          end else begin
            if (b_store) begin
              total <= total + 1'b1;
            end
            if (bv < n) begin
              if (!brev && !undirected) begin
                brev <= 1'b1;
              end else begin
                brev <= 1'b0;
                bv   <= bv + 1'b1;
              end
            end else begin
              bu   <= bu + 1'b1;
              bv   <= bu + reshuf_pkg::NODE_W'(2);
              brev <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (mod_rsp.done) begin
            state <= ST_RD_POS;
          end
        end
        ST_RD_POS: begin
          state <= ST_RD_CNT;
        end
        ST_RD_CNT: begin
          state <= ST_WR_POS;
        end
        ST_WR_POS: begin
          state <= ST_WR_CNT;
        end
        ST_WR_CNT: begin
          drawn <= drawn_inc;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && kind == reshuf_pkg::KIND_DRAW && no_draw) begin
      res.edge_from <= '0;
      res.edge_to   <= '0;
      res.last_edge <= 1'b0;
      res.exhausted <= 1'b1;
    end
    if (state == ST_DIV && mod_rsp.done) begin
      pos <= pos_full[reshuf_pkg::ADDR_W-1:0];
    end
    if (state == ST_RD_CNT) begin
      picked <= ram_rdata;
    end
    if (state == ST_WR_CNT) begin
      res.edge_from <= picked[reshuf_pkg::PAIR_W-1:reshuf_pkg::ID_W];
      res.edge_to   <= picked[reshuf_pkg::ID_W-1:0];
      res.last_edge <= (drawn_inc == limit);
      res.exhausted <= 1'b0;
    end
  end

endmodule

[src/random_edge_sampler_partial_shuffle_top.sv]
// Draws distinct graph edges by a partial Fisher-Yates shuffle over a table of candidate
// node pairs held in a 256-entry single-write, single-read RAM. A start transaction
// rebuilds the table, writing at most one entry per cycle as the node walk advances,
// then latches the clamped limit; no result is returned for it. A draw transaction runs
// the remainder unit, which retires four bits of the random word per cycle, then two
// reads and two write-backs on the single RAM port pair to swap the picked entry into
// place, and then hands the result over. A draw that finds nothing left skips these
// steps and returns an exhausted result. One transaction is worked on at a time; the
// next is accepted once the previous one has left for the output register.
module random_edge_sampler_partial_shuffle_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [reshuf_pkg::PADDR_W-1:0]      paddr,
  input  logic [reshuf_pkg::DATA_W-1:0]       pwdata,
  output logic [reshuf_pkg::DATA_W-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [reshuf_pkg::WORD_W-1:0]       random_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [reshuf_pkg::ID_W-1:0]         edge_from,
  output logic [reshuf_pkg::ID_W-1:0]         edge_to,
  output logic                                last_edge,
  output logic                                exhausted
);

  reshuf_pkg::cfg_t     cfg;
  reshuf_pkg::mod_req_t mod_req;
  reshuf_pkg::mod_rsp_t mod_rsp;
  reshuf_pkg::result_t  res;

  logic                              idle;
  logic                              accept;
  logic                              res_valid;
  logic                              slot_free;
  logic                              ram_we;
  logic [reshuf_pkg::ADDR_W-1:0]     ram_waddr;
  logic [reshuf_pkg::PAIR_W-1:0]     ram_wdata;
  logic [reshuf_pkg::ADDR_W-1:0]     ram_raddr;
  logic [reshuf_pkg::PAIR_W-1:0]     ram_rdata;
  logic                              cfg_write;
  logic [1:0]                        reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count   <= reshuf_pkg::NODE_COUNT_W'(2);
      cfg.edge_limit   <= '0;
      cfg.edge_options <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        reshuf_pkg::REG_NODE_COUNT: begin
          cfg.node_count <= pwdata[reshuf_pkg::NODE_COUNT_W-1:0];
        end
        reshuf_pkg::REG_EDGE_LIMIT: begin
          cfg.edge_limit <= pwdata[reshuf_pkg::EDGE_LIMIT_W-1:0];
        end
        reshuf_pkg::REG_EDGE_OPTIONS: begin
          cfg.edge_options <= pwdata[reshuf_pkg::OPTIONS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      reshuf_pkg::REG_NODE_COUNT:   prdata = reshuf_pkg::DATA_W'(cfg.node_count);
      reshuf_pkg::REG_EDGE_LIMIT:   prdata = reshuf_pkg::DATA_W'(cfg.edge_limit);
      reshuf_pkg::REG_EDGE_OPTIONS: prdata = reshuf_pkg::DATA_W'(cfg.edge_options);
      default:                      prdata = '0;
    endcase
  end

  assign in_stall  = !idle;
  assign accept    = in_valid && idle;
  assign slot_free = !out_valid || !out_stall;

  reshuf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .word      (random_word),
    .cfg       (cfg),
    .idle      (idle),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_take  (slot_free),
    .res       (res)
  );

  reshuf_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  reshuf_ram #(
    .DEPTH (reshuf_pkg::TABLE_DEPTH),
    .WIDTH (reshuf_pkg::PAIR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      edge_from <= res.edge_from;
      edge_to   <= res.edge_to;
      last_edge <= res.last_edge;
      exhausted <= res.exhausted;
    end
  end

endmodule

[src/reshuf_checker.sv]
module reshuf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [reshuf_pkg::PADDR_W-1:0]      paddr,
  input logic [reshuf_pkg::DATA_W-1:0]       pwdata,
  input logic [reshuf_pkg::DATA_W-1:0]       prdata,
  input logic                                pready,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                kind,
  input logic [reshuf_pkg::WORD_W-1:0]       random_word,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [reshuf_pkg::ID_W-1:0]         edge_from,
  input logic [reshuf_pkg::ID_W-1:0]         edge_to,
  input logic                                last_edge,
  input logic                                exhausted
);

  // Every transaction keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> edge_from == '0 && edge_to == '0 && !last_edge)
    else $error("exhausted result carries edge data");

  // A start produces no result, so nothing new shows up right after one is accepted.
  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == reshuf_pkg::KIND_START && !out_valid |=> !out_valid)
    else $error("result appeared after a start");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edge_from) && $stable(edge_to)
      && $stable(last_edge) && $stable(exhausted))
    else $error("stalled result changed");

endmodule

bind random_edge_sampler_partial_shuffle_top reshuf_checker u_reshuf_checker (.*);
